// ----- rtl/core/sie_pkg.sv -----
// shared types, constants and codes of the sparse image expander
package sie_pkg;

  localparam int BYTE_W = 8;
  localparam int HALF_W = 16;
  localparam int WORD_W = 32;
  localparam int KIND_W = 3;
  localparam int ERR_W  = 3;

  localparam int SECTOR_BYTES = 512;
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int BLK_SECT_W   = WORD_W - SECTOR_SHIFT;
  localparam int PROD_W       = WORD_W + BLK_SECT_W;

  localparam int RES_QUEUE_DEPTH = 8;

  localparam logic [WORD_W-1:0] MAGIC_RESET   = 32'hED26_FF3A;
  localparam logic [HALF_W-1:0] FILE_HDR_LEN  = 16'd28;
  localparam logic [HALF_W-1:0] CHUNK_HDR_LEN = 16'd12;
  localparam logic [WORD_W-1:0] FILL_PAYLOAD  = 32'd4;

  // chunk type words
  localparam logic [HALF_W-1:0] CHUNK_RAW      = 16'hCAC1;
  localparam logic [HALF_W-1:0] CHUNK_FILL     = 16'hCAC2;
  localparam logic [HALF_W-1:0] CHUNK_DONTCARE = 16'hCAC3;
  localparam logic [HALF_W-1:0] CHUNK_CRC      = 16'hCAC4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RAW   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FILL  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DONE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR = 3'd4;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
  localparam logic [ERR_W-1:0] ERR_MAGIC      = 3'd1;
  localparam logic [ERR_W-1:0] ERR_BLOCK_SIZE = 3'd2;
  localparam logic [ERR_W-1:0] ERR_HDR_SIZE   = 3'd3;
  localparam logic [ERR_W-1:0] ERR_CHUNK_SIZE = 3'd4;
  localparam logic [ERR_W-1:0] ERR_CHUNK_TYPE = 3'd5;
  localparam logic [ERR_W-1:0] ERR_TRUNCATED  = 3'd6;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_of_image;
    logic              last_of_image;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [WORD_W-1:0] start_sector;
    logic [WORD_W-1:0] sector_count;
    logic [WORD_W-1:0] fill_word;
    logic [BYTE_W-1:0] raw_byte;
    logic [ERR_W-1:0]  error_code;
    logic              last_of_run;
  } res_t;

  // up to two results of one byte, in order
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ----- rtl/core/sie_channels.sv -----
// valid/ready channel interfaces of the sparse image expander
interface sie_in_if;
  import sie_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              first_of_image;
  logic              last_of_image;
  modport source (output valid, data_byte, first_of_image, last_of_image, input ready);
  modport sink (input valid, data_byte, first_of_image, last_of_image, output ready);
endinterface

interface sie_out_if;
  import sie_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [WORD_W-1:0] start_sector;
  logic [WORD_W-1:0] sector_count;
  logic [WORD_W-1:0] fill_word;
  logic [BYTE_W-1:0] raw_byte;
  logic [ERR_W-1:0]  error_code;
  logic              last_of_run;
  modport source (output valid, result_kind, start_sector, sector_count, fill_word,
                  raw_byte, error_code, last_of_run, input ready);
  modport sink (input valid, result_kind, start_sector, sector_count, fill_word,
                raw_byte, error_code, last_of_run, output ready);
endinterface

interface sie_cfg_if;
  import sie_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] sparse_magic;
  modport source (output valid, sparse_magic, input ready);
  modport sink (input valid, sparse_magic, output ready);
endinterface

// ----- rtl/core/sie_parser.sv -----
// byte-serial parse of file header and chunks, up to two results per byte
module sie_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  input  sie_pkg::item_t                item,
  input  logic [sie_pkg::WORD_W-1:0]    magic,
  output sie_pkg::push_t                push
);
  import sie_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_FHDR  = 3'd1;
  localparam logic [2:0] PH_FSKIP = 3'd2;
  localparam logic [2:0] PH_CHDR  = 3'd3;
  localparam logic [2:0] PH_CDATA = 3'd4;

  logic [2:0]        phase_r, cur_ph, ph_nxt;
  logic [WORD_W-1:0] cnt_r, cur_cnt, cnt_nxt, cnt_inc;
  logic [WORD_W-1:0] shift_r, cur_shift, shift_nxt;
  logic [WORD_W-1:0] blk_r, cur_blk, blk_nxt;
  logic [HALF_W-1:0] fhb_r, cur_fhb, fhb_nxt;
  logic [HALF_W-1:0] chb_r, cur_chb, chb_nxt;
  logic [WORD_W-1:0] left_r, cur_left, left_nxt;
  logic [HALF_W-1:0] kind_r, cur_kind, kind_nxt;
  logic [WORD_W-1:0] blocks_r, cur_blocks, blocks_nxt;
  logic [WORD_W-1:0] total_r, cur_total, total_nxt;
  logic [WORD_W-1:0] sector_r, cur_sector, sector_nxt;
  logic [WORD_W-1:0] fill_r, cur_fill, fill_nxt;
  logic [PROD_W-1:0] prod_r;

  logic [WORD_W-1:0] chunk_sect, payload;
  logic              raw_len_ok;
  logic              do_finish, start_ch, prim_v, sec_v, trunc_v;
  res_t              prim, sec, trunc;
  res_t              r0, r1;
  logic [1:0]        n;
  logic [KIND_W-1:0] last_kind;

  // sectors of the current chunk, and a product that also checks the raw length
  always_ff @(posedge clk) begin
    prod_r <= blocks_r * blk_r[WORD_W-1:SECTOR_SHIFT];
  end

  assign chunk_sect = prod_r[WORD_W-1:0];

  always_comb begin
    if (item.first_of_image) begin
      cur_ph     = PH_FHDR;
      cur_cnt    = '0;
      cur_shift  = '0;
      cur_blk    = '0;
      cur_fhb    = '0;
      cur_chb    = '0;
      cur_left   = '0;
      cur_kind   = '0;
      cur_blocks = '0;
      cur_total  = '0;
      cur_sector = '0;
      cur_fill   = '0;
    end else begin
      cur_ph     = phase_r;
      cur_cnt    = cnt_r;
      cur_shift  = shift_r;
      cur_blk    = blk_r;
      cur_fhb    = fhb_r;
      cur_chb    = chb_r;
      cur_left   = left_r;
      cur_kind   = kind_r;
      cur_blocks = blocks_r;
      cur_total  = total_r;
      cur_sector = sector_r;
      cur_fill   = fill_r;
    end

    ph_nxt     = cur_ph;
    cnt_nxt    = cur_cnt;
    shift_nxt  = cur_shift;
    blk_nxt    = cur_blk;
    fhb_nxt    = cur_fhb;
    chb_nxt    = cur_chb;
    left_nxt   = cur_left;
    kind_nxt   = cur_kind;
    blocks_nxt = cur_blocks;
    total_nxt  = cur_total;
    sector_nxt = cur_sector;
    fill_nxt   = cur_fill;

    cnt_inc    = cur_cnt + 32'd1;
    payload    = '0;
    raw_len_ok = 1'b0;
    do_finish  = 1'b0;
    start_ch   = 1'b0;
    prim_v     = 1'b0;
    sec_v      = 1'b0;
    prim       = '0;
    sec        = '0;

    unique case (cur_ph)
      PH_FHDR: begin
        if (cur_cnt < 32'd4) begin
          shift_nxt[{cur_cnt[1:0], 3'b000} +: BYTE_W] = item.data_byte;
        end else if (cur_cnt >= 32'd8 && cur_cnt < 32'd10) begin
          fhb_nxt[{cur_cnt[0], 3'b000} +: BYTE_W] = item.data_byte;
        end else if (cur_cnt >= 32'd10 && cur_cnt < 32'd12) begin
          chb_nxt[{cur_cnt[0], 3'b000} +: BYTE_W] = item.data_byte;
        end else if (cur_cnt >= 32'd12 && cur_cnt < 32'd16) begin
          blk_nxt[{cur_cnt[1:0], 3'b000} +: BYTE_W] = item.data_byte;
        end else if (cur_cnt >= 32'd20 && cur_cnt < 32'd24) begin
          left_nxt[{cur_cnt[1:0], 3'b000} +: BYTE_W] = item.data_byte;
        end
        cnt_nxt = cnt_inc;
        if (cnt_inc == {16'b0, FILE_HDR_LEN}) begin
          // header checks in order: magic, block size, header sizes
          if (cur_shift != magic) begin
            sec_v = 1'b1;
            sec.result_kind = KIND_ERROR;
            sec.error_code  = ERR_MAGIC;
          end else if (cur_blk == '0 || cur_blk[SECTOR_SHIFT-1:0] != '0) begin
            sec_v = 1'b1;
            sec.result_kind = KIND_ERROR;
            sec.error_code  = ERR_BLOCK_SIZE;
          end else if (cur_fhb < FILE_HDR_LEN || cur_chb < CHUNK_HDR_LEN) begin
            sec_v = 1'b1;
            sec.result_kind = KIND_ERROR;
            sec.error_code  = ERR_HDR_SIZE;
          end else if (cur_left == '0) begin
            sec_v = 1'b1;
            sec.result_kind = KIND_DONE;
            ph_nxt = PH_IDLE;
          end else if (cur_fhb > FILE_HDR_LEN) begin
            ph_nxt  = PH_FSKIP;
            cnt_nxt = '0;
          end else begin
            start_ch = 1'b1;
          end
        end
      end
      PH_FSKIP: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc == {16'b0, cur_fhb - FILE_HDR_LEN}) begin
          start_ch = 1'b1;
        end
      end
      PH_CHDR: begin
        if (cur_cnt < 32'd2) begin
          kind_nxt[{cur_cnt[0], 3'b000} +: BYTE_W] = item.data_byte;
        end else if (cur_cnt >= 32'd4 && cur_cnt < 32'd8) begin
          blocks_nxt[{cur_cnt[1:0], 3'b000} +: BYTE_W] = item.data_byte;
        end else if (cur_cnt >= 32'd8 && cur_cnt < 32'd12) begin
          total_nxt[{cur_cnt[1:0], 3'b000} +: BYTE_W] = item.data_byte;
        end
        cnt_nxt = cnt_inc;
        if (cnt_inc == {16'b0, cur_chb}) begin
          payload    = total_nxt - {16'b0, cur_chb};
          raw_len_ok = (prod_r[PROD_W-1:BLK_SECT_W] == '0) &&
                       (payload[SECTOR_SHIFT-1:0] == '0) &&
                       (prod_r[BLK_SECT_W-1:0] == payload[WORD_W-1:SECTOR_SHIFT]);
          if (total_nxt < {16'b0, cur_chb}) begin
            sec_v = 1'b1;
            sec.result_kind = KIND_ERROR;
            sec.error_code  = ERR_CHUNK_SIZE;
          end else if (cur_kind == CHUNK_RAW && !raw_len_ok) begin
            sec_v = 1'b1;
            sec.result_kind = KIND_ERROR;
            sec.error_code  = ERR_CHUNK_SIZE;
          end else if (cur_kind == CHUNK_FILL && payload != FILL_PAYLOAD) begin
            sec_v = 1'b1;
            sec.result_kind = KIND_ERROR;
            sec.error_code  = ERR_CHUNK_SIZE;
          end else if (cur_kind != CHUNK_RAW && cur_kind != CHUNK_FILL &&
                       cur_kind != CHUNK_DONTCARE && cur_kind != CHUNK_CRC) begin
            sec_v = 1'b1;
            sec.result_kind = KIND_ERROR;
            sec.error_code  = ERR_CHUNK_TYPE;
          end else begin
            if (cur_kind == CHUNK_RAW && chunk_sect != '0) begin
              prim_v = 1'b1;
              prim.result_kind  = KIND_WRITE;
              prim.start_sector = cur_sector;
              prim.sector_count = chunk_sect;
            end
            total_nxt = payload;
            cnt_nxt   = '0;
            fill_nxt  = '0;
            if (payload == '0) begin
              do_finish = 1'b1;
            end else begin
              ph_nxt = PH_CDATA;
            end
          end
        end
      end
      PH_CDATA: begin
        if (cur_kind == CHUNK_RAW) begin
          prim_v = 1'b1;
          prim.result_kind = KIND_RAW;
          prim.raw_byte    = item.data_byte;
        end else if (cur_kind == CHUNK_FILL && cur_cnt < 32'd4) begin
          fill_nxt[{cur_cnt[1:0], 3'b000} +: BYTE_W] = item.data_byte;
          if (cur_cnt == 32'd3 && chunk_sect != '0) begin
            prim_v = 1'b1;
            prim.result_kind  = KIND_FILL;
            prim.start_sector = cur_sector;
            prim.sector_count = chunk_sect;
            prim.fill_word    = fill_nxt;
          end
        end
        cnt_nxt = cnt_inc;
        if (cnt_inc == cur_total) begin
          do_finish = 1'b1;
        end
      end
      default: begin
        ph_nxt = PH_IDLE;
      end
    endcase

    if (do_finish) begin
      sector_nxt = cur_sector + chunk_sect;
      left_nxt   = cur_left - 32'd1;
      if (cur_left == 32'd1) begin
        sec_v = 1'b1;
        sec.result_kind = KIND_DONE;
        ph_nxt = PH_IDLE;
      end else begin
        start_ch = 1'b1;
      end
    end

    if (start_ch) begin
      ph_nxt     = PH_CHDR;
      cnt_nxt    = '0;
      kind_nxt   = '0;
      blocks_nxt = '0;
      total_nxt  = '0;
      fill_nxt   = '0;
    end

    if (sec_v && sec.result_kind == KIND_ERROR) begin
      ph_nxt = PH_IDLE;
    end

    // a buffer that ends mid-image
    trunc   = '0;
    trunc_v = item.last_of_image && (ph_nxt != PH_IDLE);
    if (trunc_v) begin
      trunc.result_kind = KIND_ERROR;
      trunc.error_code  = ERR_TRUNCATED;
      ph_nxt = PH_IDLE;
    end

    // pack results in order
    n  = 2'd0;
    r0 = '0;
    r1 = '0;
    if (prim_v) begin
      r0 = prim;
      n  = 2'd1;
    end
    if (sec_v) begin
      if (n == 2'd0) begin
        r0 = sec;
      end else begin
        r1 = sec;
      end
      n = n + 2'd1;
    end
    if (trunc_v) begin
      if (n == 2'd0) begin
        r0 = trunc;
      end else begin
        r1 = trunc;
      end
      n = n + 2'd1;
    end
    if (n == 2'd1) begin
      r0.last_of_run = 1'b1;
    end else if (n == 2'd2) begin
      r1.last_of_run = 1'b1;
    end

    push.n  = item_valid ? n : 2'd0;
    push.r0 = r0;
    push.r1 = r1;
  end

  assign last_kind = (push.n == 2'd2) ? push.r1.result_kind : push.r0.result_kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
    end else if (item_valid) begin
      phase_r <= ph_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // parse fields are rebuilt from zero at every image start
  always_ff @(posedge clk) begin
    if (item_valid) begin
      shift_r  <= shift_nxt;
      blk_r    <= blk_nxt;
      fhb_r    <= fhb_nxt;
      chb_r    <= chb_nxt;
      left_r   <= left_nxt;
      kind_r   <= kind_nxt;
      blocks_r <= blocks_nxt;
      total_r  <= total_nxt;
      sector_r <= sector_nxt;
      fill_r   <= fill_nxt;
    end
  end

  a_error_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && push.n != 2'd0 && last_kind == KIND_ERROR |=> phase_r == PH_IDLE)
    else $error("parser did not stop after an error");

  a_raw_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && push.n != 2'd0 && push.r0.result_kind == KIND_RAW |-> cur_ph == PH_CDATA)
    else $error("raw byte outside a chunk payload");

endmodule

// ----- rtl/core/sie_result_queue.sv -----
// result queue taking up to two results per cycle and giving one beat per cycle while the sink is ready
module sie_result_queue #(
  parameter int DEPTH = sie_pkg::RES_QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sie_pkg::push_t               push,
  output logic [$clog2(DEPTH+1)-1:0]   count,
  sie_out_if.source                    out_chan
);
  import sie_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  res_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr1, wr_ptr2, wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;
  res_t             head;

  assign wr_ptr1 = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign wr_ptr2 = (wr_ptr1 == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr1 + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  assign pop       = out_chan.valid && out_chan.ready;
  assign count_nxt = count_r + CNT_W'(push.n) - CNT_W'(pop);
  assign count     = count_r;

  always_comb begin
    case (push.n)
      2'd1:    wr_ptr_nxt = wr_ptr1;
      2'd2:    wr_ptr_nxt = wr_ptr2;
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

  assign head                  = mem_r[rd_ptr_r];
  assign out_chan.valid        = (count_r != '0);
  assign out_chan.result_kind  = head.result_kind;
  assign out_chan.start_sector = head.start_sector;
  assign out_chan.sector_count = head.sector_count;
  assign out_chan.fill_word    = head.fill_word;
  assign out_chan.raw_byte     = head.raw_byte;
  assign out_chan.error_code   = head.error_code;
  assign out_chan.last_of_run  = head.last_of_run;

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("result queue count beyond depth");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> ({1'b0, count_r} + (CNT_W + 1)'(push.n)) <= (CNT_W + 1)'(DEPTH))
    else $error("results pushed into a full queue");

endmodule

// ----- rtl/core/sparse_image_expander_core.sv -----
// top level of the sparse image expander: input register, parser, result queue
// an accepted byte passes the input register and the parser into the result queue before its first result beat shows
// throughput: one byte per cycle while in_ready is high; a byte that yields two results takes two output beats
// in_ready drops while the result queue cannot take two more results for each byte in flight
// reset (rst_n low, synchronous): parser idle, queue empty, sparse_magic back to 0xED26FF3A
// there is no clearing pass; the block is ready as soon as reset is released
module sparse_image_expander_core #(
  parameter int QUEUE_DEPTH = sie_pkg::RES_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  sie_cfg_if.sink   cfg_chan,
  sie_in_if.sink    in_chan,
  sie_out_if.source out_chan
);
  import sie_pkg::*;

  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int NEED_W = CNT_W + 2;

  // expected magic word; the user writes it only while the block is idle, the block itself does not enforce this
  logic [WORD_W-1:0] magic_r;

  // input register: one byte, handed to the parser the cycle after its beat
  logic              in_valid_r;
  item_t             item_r;

  logic [CNT_W-1:0]  q_count;
  logic [NEED_W-1:0] need;
  push_t             push;

  // the configuration write always lands at once
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= MAGIC_RESET;
    end else if (cfg_chan.valid) begin
      magic_r <= cfg_chan.sparse_magic;
    end
  end

  // room check: queue entries in use, two slots for the byte held in the
  // input register and two for the byte that would be taken now
  assign need = {2'b00, q_count} + NEED_W'(2) + (in_valid_r ? NEED_W'(2) : '0);
  assign in_chan.ready = (need <= NEED_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_chan.valid && in_chan.ready;
    end
  end

  // byte payload needs no reset
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_r.data_byte      <= in_chan.data_byte;
      item_r.first_of_image <= in_chan.first_of_image;
      item_r.last_of_image  <= in_chan.last_of_image;
    end
  end

  // header and chunk parse; the parser never stalls, the room check
  // above keeps space for whatever it produces
  sie_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid_r),
    .item       (item_r),
    .magic      (magic_r),
    .push       (push)
  );

  // results wait here so a stalled sink does not stop the parser at once
  sie_result_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_result_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .count    (q_count),
    .out_chan (out_chan)
  );

endmodule

// ----- tb/sparse_image_expander_core_tb.sv -----
// self-checking testbench of the sparse image expander core
`timescale 1ns / 100ps

module sparse_image_expander_core_tb;
  import sie_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTED  = 50;

  // parser stages of the expectation model
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILE_HDR,
    ST_HDR_SKIP,
    ST_CHUNK_HDR,
    ST_CHUNK_DATA
  } stage_e;

  logic clk;
  logic rst_n;

  sie_cfg_if cfg_chan ();
  sie_in_if  in_chan ();
  sie_out_if out_chan ();

  sparse_image_expander_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // idle percentages of both sides, changed per phase
  int send_gap_pct;
  int recv_stall_pct;

  // expectation model state: parser position, header fields, chunk fields
  stage_e      stage;
  logic [31:0] pos;
  logic [31:0] magic_acc;
  logic [31:0] blk_size;
  logic [15:0] fhdr_len;
  logic [15:0] chdr_len;
  logic [31:0] chunks_remaining;
  logic [15:0] ck_type;
  logic [31:0] ck_blocks;
  logic [31:0] ck_size;
  logic [31:0] sector_pos;
  logic [31:0] fill_acc;
  logic [31:0] magic_cfg;

  res_t byte_results[$];      // results of the byte being predicted
  res_t expected_results[$];  // results still to come out of the block

  logic [7:0] image_bytes[$]; // image under construction
  bit         has_raw_data;

  int error_count;
  int parsed_bytes;
  int images_sent;
  int magic_writes;
  int cycle_count;
  int kind_seen[8];
  int err_seen[8];

  // ---------------------------------------------------------------------------
  // expectation model
  // ---------------------------------------------------------------------------

  function automatic res_t make_result(logic [KIND_W-1:0] kind, logic [31:0] start,
                                       logic [31:0] count, logic [31:0] fill,
                                       logic [7:0] raw, logic [ERR_W-1:0] err);
    res_t r;
    r.result_kind  = kind;
    r.start_sector = start;
    r.sector_count = count;
    r.fill_word    = fill;
    r.raw_byte     = raw;
    r.error_code   = err;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  function automatic void clear_parser();
    stage            = ST_IDLE;
    pos              = '0;
    magic_acc        = '0;
    blk_size         = '0;
    fhdr_len         = '0;
    chdr_len         = '0;
    chunks_remaining = '0;
    ck_type          = '0;
    ck_blocks        = '0;
    ck_size          = '0;
    sector_pos       = '0;
    fill_acc         = '0;
  endfunction

  function automatic void abort_image(logic [ERR_W-1:0] code);
    stage = ST_IDLE;
    byte_results.push_back(make_result(KIND_ERROR, '0, '0, '0, '0, code));
  endfunction

  // sectors covered by the current chunk, wrapping at 32 bits
  function automatic logic [31:0] chunk_sector_count();
    return ck_blocks * (blk_size >> SECTOR_SHIFT);
  endfunction

  function automatic void open_chunk_header();
    stage     = ST_CHUNK_HDR;
    pos       = '0;
    ck_type   = '0;
    ck_blocks = '0;
    ck_size   = '0;
    fill_acc  = '0;
  endfunction

  function automatic void close_chunk();
    sector_pos       = sector_pos + chunk_sector_count();
    chunks_remaining = chunks_remaining - 1;
    if (chunks_remaining == 0) begin
      stage = ST_IDLE;
      byte_results.push_back(make_result(KIND_DONE, '0, '0, '0, '0, ERR_NONE));
    end else begin
      open_chunk_header();
    end
  endfunction

  // checks in order: magic, block size, header sizes
  function automatic void file_header_complete();
    if (magic_acc != magic_cfg) begin
      abort_image(ERR_MAGIC);
    end else if (blk_size == 0 || blk_size[SECTOR_SHIFT-1:0] != '0) begin
      abort_image(ERR_BLOCK_SIZE);
    end else if (fhdr_len < FILE_HDR_LEN || chdr_len < CHUNK_HDR_LEN) begin
      abort_image(ERR_HDR_SIZE);
    end else if (chunks_remaining == 0) begin
      stage = ST_IDLE;
      byte_results.push_back(make_result(KIND_DONE, '0, '0, '0, '0, ERR_NONE));
    end else if (fhdr_len > FILE_HDR_LEN) begin
      stage = ST_HDR_SKIP;
      pos   = '0;
    end else begin
      open_chunk_header();
    end
  endfunction

  function automatic void chunk_header_complete();
    logic [31:0] payload;
    if (ck_size < {16'd0, chdr_len}) begin
      abort_image(ERR_CHUNK_SIZE);
      return;
    end
    payload = ck_size - {16'd0, chdr_len};
    if (ck_type == CHUNK_RAW) begin
      if ({32'd0, ck_blocks} * {32'd0, blk_size} != {32'd0, payload}) begin
        abort_image(ERR_CHUNK_SIZE);
        return;
      end
      if (chunk_sector_count() != 0)
        byte_results.push_back(make_result(KIND_WRITE, sector_pos, chunk_sector_count(),
                                           '0, '0, ERR_NONE));
    end else if (ck_type == CHUNK_FILL) begin
      if (payload != FILL_PAYLOAD) begin
        abort_image(ERR_CHUNK_SIZE);
        return;
      end
    end else if (ck_type != CHUNK_DONTCARE && ck_type != CHUNK_CRC) begin
      abort_image(ERR_CHUNK_TYPE);
      return;
    end
    ck_size  = payload;
    pos      = '0;
    fill_acc = '0;
    if (payload == 0)
      close_chunk();
    else
      stage = ST_CHUNK_DATA;
  endfunction

  // works out the results of one accepted byte and queues them
  function automatic void predict_byte(logic [7:0] b, logic first, logic last);
    int unsigned o;
    res_t        r;
    byte_results.delete();
    if (first) begin
      clear_parser();
      stage = ST_FILE_HDR;
    end
    if (stage != ST_IDLE)
      parsed_bytes++;
    o = pos;
    case (stage)
      ST_FILE_HDR: begin
        if (o < 4)
          magic_acc[8*o +: 8] = b;
        else if (o >= 8 && o < 10)
          fhdr_len[8*(o-8) +: 8] = b;
        else if (o >= 10 && o < 12)
          chdr_len[8*(o-10) +: 8] = b;
        else if (o >= 12 && o < 16)
          blk_size[8*(o-12) +: 8] = b;
        else if (o >= 20 && o < 24)
          chunks_remaining[8*(o-20) +: 8] = b;
        pos = o + 1;
        if (pos == FILE_HDR_LEN)
          file_header_complete();
      end
      ST_HDR_SKIP: begin
        pos = o + 1;
        if (pos == {16'd0, fhdr_len - FILE_HDR_LEN})
          open_chunk_header();
      end
      ST_CHUNK_HDR: begin
        if (o < 2)
          ck_type[8*o +: 8] = b;
        else if (o >= 4 && o < 8)
          ck_blocks[8*(o-4) +: 8] = b;
        else if (o >= 8 && o < 12)
          ck_size[8*(o-8) +: 8] = b;
        pos = o + 1;
        if (pos == {16'd0, chdr_len})
          chunk_header_complete();
      end
      ST_CHUNK_DATA: begin
        if (ck_type == CHUNK_RAW) begin
          byte_results.push_back(make_result(KIND_RAW, '0, '0, '0, b, ERR_NONE));
        end else if (ck_type == CHUNK_FILL && o < 4) begin
          fill_acc[8*o +: 8] = b;
          if (o == 3 && chunk_sector_count() != 0)
            byte_results.push_back(make_result(KIND_FILL, sector_pos, chunk_sector_count(),
                                               fill_acc, '0, ERR_NONE));
        end
        pos = o + 1;
        if (pos == ck_size)
          close_chunk();
      end
      default: ;
    endcase
    if (last && stage != ST_IDLE)
      abort_image(ERR_TRUNCATED);
    if (byte_results.size() > 0) begin
      r = byte_results.pop_back();
      r.last_of_run = 1'b1;
      byte_results.push_back(r);
    end
    foreach (byte_results[i])
      expected_results.push_back(byte_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // clock, reset, receiver, checker, watchdog
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver side: ready toggles at random per the current stall rate
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (error_count < MAX_PRINTED)
      $display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h",
               cycle_count, what, want, got);
    error_count++;
  endtask

  task automatic compare_result(res_t want, res_t got);
    if (got.result_kind !== want.result_kind)
      report_mismatch("result_kind", want.result_kind, got.result_kind);
    if (got.start_sector !== want.start_sector)
      report_mismatch("start_sector", want.start_sector, got.start_sector);
    if (got.sector_count !== want.sector_count)
      report_mismatch("sector_count", want.sector_count, got.sector_count);
    if (got.fill_word !== want.fill_word)
      report_mismatch("fill_word", want.fill_word, got.fill_word);
    if (got.raw_byte !== want.raw_byte)
      report_mismatch("raw_byte", want.raw_byte, got.raw_byte);
    if (got.error_code !== want.error_code)
      report_mismatch("error_code", want.error_code, got.error_code);
    if (got.last_of_run !== want.last_of_run)
      report_mismatch("last_of_run", want.last_of_run, got.last_of_run);
  endtask

  // every accepted result beat is matched against the oldest expectation
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.result_kind  = out_chan.result_kind;
      got.start_sector = out_chan.start_sector;
      got.sector_count = out_chan.sector_count;
      got.fill_word    = out_chan.fill_word;
      got.raw_byte     = out_chan.raw_byte;
      got.error_code   = out_chan.error_code;
      got.last_of_run  = out_chan.last_of_run;
      if (expected_results.size() == 0) begin
        report_mismatch("beat with nothing expected, kind", '0, got.result_kind);
      end else begin
        want = expected_results.pop_front();
        compare_result(want, got);
        kind_seen[want.result_kind]++;
        err_seen[want.error_code]++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one input beat, with a random gap ahead of it
  task automatic send_byte(logic [7:0] b, logic first, logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.data_byte      <= b;
    in_chan.first_of_image <= first;
    in_chan.last_of_image  <= last;
    do @(posedge clk); while (!in_chan.ready);
    predict_byte(b, first, last);
  endtask

  // lets every expected result out, plus slack for bytes without results
  task automatic wait_for_drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic write_magic(logic [31:0] value);
    cfg_chan.valid        <= 1'b1;
    cfg_chan.sparse_magic <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    magic_cfg = value;
    magic_writes++;
    cfg_chan.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // image builders
  // ---------------------------------------------------------------------------

  function automatic void put_le(logic [31:0] value, int n);
    for (int i = 0; i < n; i++)
      image_bytes.push_back(value[8*i +: 8]);
  endfunction

  function automatic void put_random(int n);
    for (int i = 0; i < n; i++)
      image_bytes.push_back(8'($urandom));
  endfunction

  // 28 parsed bytes plus any extra header bytes
  function automatic void put_file_header(logic [31:0] magic, logic [15:0] fhdr,
                                          logic [15:0] chdr, logic [31:0] blk,
                                          logic [31:0] nchunks);
    put_le(magic, 4);
    put_random(4);
    put_le({16'd0, fhdr}, 2);
    put_le({16'd0, chdr}, 2);
    put_le(blk, 4);
    put_random(4);
    put_le(nchunks, 4);
    put_random(4);
    put_random(int'(fhdr) - int'(FILE_HDR_LEN));
  endfunction

  function automatic void put_chunk(logic [15:0] kind, logic [31:0] blocks,
                                    logic [31:0] total, logic [15:0] chdr, int body);
    put_le({16'd0, kind}, 2);
    put_random(2);
    put_le(blocks, 4);
    put_le(total, 4);
    put_random(int'(chdr) - int'(CHUNK_HDR_LEN));
    put_random(body);
  endfunction

  // sends the built image; stop_at < 0 sends it whole
  task automatic send_image(int stop_at, bit with_last);
    int n;
    n = (stop_at >= 0 && stop_at < image_bytes.size()) ? stop_at + 1 : image_bytes.size();
    for (int i = 0; i < n; i++)
      send_byte(image_bytes[i], i == 0, with_last && i == n - 1);
    image_bytes.delete();
    images_sent++;
  endtask

  function automatic void put_random_chunk(logic [31:0] blk, logic [15:0] chdr);
    logic [31:0] blocks;
    int          body;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: begin
        blocks = (blk == SECTOR_BYTES && $urandom_range(0, 3) == 0) ? 32'd1 : 32'd0;
        body   = int'(blocks * blk);
        has_raw_data |= (blocks != 0);
        put_chunk(CHUNK_RAW, blocks, chdr + body, chdr, body);
      end
      5, 6, 7, 8, 9: begin
        case ($urandom_range(0, 3))
          0:       blocks = '0;
          1:       blocks = $urandom_range(1, 16);
          2:       blocks = $urandom;
          default: blocks = 32'd1;
        endcase
        put_chunk(CHUNK_FILL, blocks, chdr + 4, chdr, 4);
      end
      10, 11, 12, 13: begin
        blocks = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 64);
        body   = $urandom_range(0, 3);
        put_chunk(CHUNK_DONTCARE, blocks, chdr + body, chdr, body);
      end
      14, 15, 16: begin
        put_chunk(CHUNK_CRC, $urandom_range(0, 2), chdr + 4, chdr, 4);
      end
      17: begin
        // unknown type word
        body = $urandom_range(0, 3);
        put_chunk(16'($urandom), $urandom, chdr + body, chdr, body);
      end
      18: begin
        // total size shorter than the chunk header
        put_chunk(CHUNK_RAW + 16'($urandom_range(0, 3)), 0, $urandom_range(0, chdr - 1),
                  chdr, 0);
      end
      default: begin
        // payload length does not match the kind
        if ($urandom_range(0, 1))
          put_chunk(CHUNK_RAW, 1, chdr + 4, chdr, 4);
        else
          put_chunk(CHUNK_FILL, 1, chdr + 5, chdr, 5);
      end
    endcase
  endfunction

  // well-formed image with random content; sometimes broken, cut short or abandoned
  task automatic send_random_image();
    logic [31:0] blk;
    logic [15:0] fhdr;
    logic [15:0] chdr;
    int          nchunks;
    int          cut;
    int          idx;
    bit          keep_last;
    image_bytes.delete();
    has_raw_data = 0;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: blk = SECTOR_BYTES;
      4:          blk = 32'd1024;
      5:          blk = 32'd4096;
      6:          blk = ($urandom | 32'h200) & 32'hFFFF_FE00;
      default:    blk = SECTOR_BYTES * $urandom_range(1, 8);
    endcase
    fhdr    = ($urandom_range(0, 5) == 0) ? FILE_HDR_LEN + $urandom_range(1, 4) : FILE_HDR_LEN;
    chdr    = ($urandom_range(0, 5) == 0) ? CHUNK_HDR_LEN + $urandom_range(1, 4) : CHUNK_HDR_LEN;
    nchunks = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    put_file_header(magic_cfg, fhdr, chdr, blk, nchunks);
    repeat (nchunks) put_random_chunk(blk, chdr);
    if ($urandom_range(0, 9) == 0) begin
      idx = $urandom_range(0, image_bytes.size() - 1);
      image_bytes[idx] = image_bytes[idx] ^ 8'($urandom_range(1, 255));
    end
    // raw payloads are long, so most of them get cut short
    cut = -1;
    if ((has_raw_data && $urandom_range(0, 3) != 0) || $urandom_range(0, 7) == 0)
      cut = $urandom_range(0, image_bytes.size() - 1);
    keep_last = !(cut >= 0 && $urandom_range(0, 3) == 0);
    send_image(cut, keep_last);
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0, 1'($urandom));
  endtask

  // random bytes with random markers
  task automatic send_noise();
    repeat ($urandom_range(1, 8))
      send_byte(8'($urandom), $urandom_range(0, 15) == 0, $urandom_range(0, 3) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // file header checks, their order, zero chunks and extra header bytes
  task automatic test_header_checks();
    put_file_header(magic_cfg, 28, 12, 4096, 0);
    send_image(-1, 1);
    put_file_header(~magic_cfg, 28, 12, 0, 1);        // magic checked before block size
    put_chunk(CHUNK_DONTCARE, 0, 12, 12, 0);
    send_image(-1, 1);
    put_file_header(magic_cfg, 28, 12, 0, 1);
    put_chunk(CHUNK_DONTCARE, 0, 12, 12, 0);
    send_image(-1, 1);
    put_file_header(magic_cfg, 27, 12, 513, 1);       // block size before header size
    put_chunk(CHUNK_DONTCARE, 0, 12, 12, 0);
    send_image(-1, 1);
    put_file_header(magic_cfg, 27, 12, 512, 1);
    put_chunk(CHUNK_DONTCARE, 0, 12, 12, 0);
    send_image(-1, 1);
    put_file_header(magic_cfg, 28, 11, 512, 1);
    put_chunk(CHUNK_DONTCARE, 0, 11, 11, 0);
    send_image(-1, 1);
    put_file_header(magic_cfg, 28, 12, 32'hFFFF_FE00, 1);
    put_chunk(CHUNK_DONTCARE, 3, 12, 12, 0);
    send_image(-1, 1);
    put_file_header(magic_cfg, 31, 12, 1024, 1);      // extra header bytes skipped
    put_chunk(CHUNK_DONTCARE, 2, 12, 12, 0);
    send_image(-1, 1);
    put_file_header(magic_cfg, 30, 12, 512, 0);       // done before the extra bytes
    send_image(-1, 1);
  endtask

  // every chunk kind, zero-sector commands, sector wrap and chunk errors
  task automatic test_chunk_kinds();
    put_file_header(magic_cfg, 28, 16, 512, 6);
    put_chunk(CHUNK_RAW, 1, 16 + 512, 16, 512);
    put_chunk(CHUNK_DONTCARE, 5, 16, 16, 0);
    put_chunk(CHUNK_CRC, 0, 20, 16, 4);
    put_chunk(CHUNK_RAW, 0, 16, 16, 0);
    put_chunk(CHUNK_FILL, 0, 20, 16, 4);
    put_chunk(CHUNK_FILL, 3, 20, 16, 4);               // fill command and done together
    send_image(-1, 1);
    // 0x400000 sectors per block: sector position and counts wrap
    put_file_header(magic_cfg, 28, 12, 32'h8000_0000, 3);
    put_chunk(CHUNK_DONTCARE, 32'h401, 12, 12, 0);
    put_chunk(CHUNK_FILL, 32'h400, 16, 12, 4);
    put_chunk(CHUNK_FILL, 32'hFFFF_FFFF, 16, 12, 4);
    send_image(-1, 1);
    put_file_header(magic_cfg, 28, 12, 512, 2);
    put_chunk(16'h1234, 0, 11, 12, 0);                 // short total wins over bad type
    put_chunk(CHUNK_DONTCARE, 0, 12, 12, 0);
    send_image(-1, 1);
    put_file_header(magic_cfg, 28, 12, 512, 2);
    put_chunk(16'hCAC0, 0, 12, 12, 0);
    put_chunk(CHUNK_DONTCARE, 0, 12, 12, 0);
    send_image(-1, 1);
    put_file_header(magic_cfg, 28, 12, 512, 2);
    put_chunk(CHUNK_DONTCARE, 0, 12, 12, 0);
    put_chunk(16'hFFFF, 0, 12, 12, 0);
    send_image(-1, 1);
    put_file_header(magic_cfg, 28, 12, 512, 2);
    put_chunk(CHUNK_RAW, 1, 12, 12, 0);                // raw payload too short
    put_chunk(CHUNK_DONTCARE, 0, 12, 12, 0);
    send_image(-1, 1);
    put_file_header(magic_cfg, 28, 12, 512, 2);
    put_chunk(CHUNK_FILL, 1, 15, 12, 3);               // fill payload not 4 bytes
    put_chunk(CHUNK_DONTCARE, 0, 12, 12, 0);
    send_image(-1, 1);
  endtask

  // truncation everywhere, idle bytes, restart mid-image, trailing bytes
  task automatic test_truncation_and_idle();
    send_byte(8'($urandom), 1'b0, 1'b1);
    send_byte(8'($urandom), 1'b0, 1'b0);
    put_file_header(magic_cfg, 28, 12, 512, 1);
    send_image(9, 1);
    put_file_header(magic_cfg, 30, 12, 512, 1);
    put_chunk(CHUNK_DONTCARE, 0, 12, 12, 0);
    send_image(28, 1);                                 // cut inside the skipped bytes
    put_file_header(magic_cfg, 28, 12, 512, 1);
    put_chunk(CHUNK_RAW, 1, 12 + 512, 12, 512);
    send_image(28 + 12 - 1, 1);                        // write command then truncation
    put_file_header(magic_cfg, 28, 12, 512, 1);
    put_chunk(CHUNK_RAW, 1, 12 + 512, 12, 512);
    send_image(28 + 12 + 99, 1);
    put_file_header(magic_cfg, 28, 12, 1024, 2);
    put_chunk(CHUNK_FILL, 2, 16, 12, 4);
    put_chunk(CHUNK_DONTCARE, 0, 12, 12, 0);
    send_image(28 + 12 + 3, 1);                        // fill command then truncation
    put_file_header(magic_cfg, 28, 12, 512, 1);
    send_image(14, 0);                                 // abandoned, next byte restarts
    put_file_header(magic_cfg, 28, 12, 512, 1);
    put_chunk(CHUNK_CRC, 0, 16, 12, 4);
    send_image(-1, 1);
    put_file_header(magic_cfg, 28, 12, 512, 0);
    send_image(-1, 1);
    repeat (3) send_byte(8'($urandom), 1'b0, 1'($urandom));
  endtask

  // magic register at both extremes
  task automatic test_magic_register();
    wait_for_drain();
    write_magic(32'h0000_0000);
    put_file_header(32'h0000_0000, 28, 12, 512, 1);
    put_chunk(CHUNK_DONTCARE, 1, 12, 12, 0);
    send_image(-1, 1);
    put_file_header(MAGIC_RESET, 28, 12, 512, 0);
    send_image(-1, 1);
    wait_for_drain();
    write_magic(32'hFFFF_FFFF);
    put_file_header(32'hFFFF_FFFF, 28, 12, 512, 0);
    send_image(-1, 1);
    put_file_header(32'hFFFF_FFFE, 28, 12, 512, 0);
    send_image(-1, 1);
  endtask

  // random images under one idling mix and one magic setting
  task automatic test_random_images(int gap_pct, int stall_pct, logic [31:0] magic,
                                    int n_bytes);
    int start;
    wait_for_drain();
    write_magic(magic);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    start = parsed_bytes;
    while (parsed_bytes - start < n_bytes) begin
      if ($urandom_range(0, 19) == 0)
        send_noise();
      else
        send_random_image();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n                  = 1'b0;
    in_chan.valid          = 1'b0;
    in_chan.data_byte      = '0;
    in_chan.first_of_image = 1'b0;
    in_chan.last_of_image  = 1'b0;
    cfg_chan.valid         = 1'b0;
    cfg_chan.sparse_magic  = '0;
    send_gap_pct           = 32;
    recv_stall_pct         = 86;
    magic_cfg              = MAGIC_RESET;
    clear_parser();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_header_checks();
    test_chunk_kinds();
    test_truncation_and_idle();
    test_magic_register();
    test_random_images(32, 86, $urandom, 480);
    test_random_images(86, 32, MAGIC_RESET, 480);
    test_random_images(0, 0, $urandom, 490);
    wait_for_drain();

    if (expected_results.size() != 0)
      report_mismatch("results never seen, count", '0, expected_results.size());

    $display("covered %0d images, %0d parsed bytes, %0d magic writes, %0d cycles",
             images_sent, parsed_bytes, magic_writes, cycle_count);
    $display("beats: write %0d data %0d fill %0d done %0d error %0d (truncated %0d)",
             kind_seen[KIND_WRITE], kind_seen[KIND_RAW], kind_seen[KIND_FILL],
             kind_seen[KIND_DONE], kind_seen[KIND_ERROR], err_seen[ERR_TRUNCATED]);
    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/sie_pkg.sv
rtl/core/sie_channels.sv
rtl/core/sie_parser.sv
rtl/core/sie_result_queue.sv
rtl/core/sparse_image_expander_core.sv
tb/sparse_image_expander_core_tb.sv
